### hdl/color_string_nearest_palette_macros.svh
// Assertion macros shared by the color string nearest palette RTL.
// Expects a clock named clk and a synchronous active-high reset named rst in scope.
`ifndef COLOR_STRING_NEAREST_PALETTE_MACROS_SVH
`define COLOR_STRING_NEAREST_PALETTE_MACROS_SVH

// Checked only outside reset
`define CSNP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included
`define CSNP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/csnp_pkg.sv
// Shared types and constants for the color string nearest palette block.
// No dependencies; used by every module of the block.
`default_nettype none

package csnp_pkg;

  localparam int PALETTE_SIZE = 17;
  localparam int CIDX_W       = 5;

  // One parsed string handed from the parser to the search unit
  typedef struct packed {
    logic       ok;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } csnp_item_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } csnp_q_status_t;

  // Palette table, RGB packed as 8/8/8
  function automatic logic [23:0] palette_color(input logic [CIDX_W-1:0] idx);
    logic [23:0] c;
    case (idx)
      5'd0:    c = 24'h000000;
      5'd1:    c = 24'hFFFFFF;
      5'd2:    c = 24'hFF0000;
      5'd3:    c = 24'h00FF00;
      5'd4:    c = 24'h0000FF;
      5'd5:    c = 24'hFFFF00;
      5'd6:    c = 24'h00FFFF;
      5'd7:    c = 24'hFF00FF;
      5'd8:    c = 24'hC0C0C0;
      5'd9:    c = 24'h808080;
      5'd10:   c = 24'h800000;
      5'd11:   c = 24'h808000;
      5'd12:   c = 24'h008000;
      5'd13:   c = 24'h800080;
      5'd14:   c = 24'h008080;
      5'd15:   c = 24'h000080;
      5'd16:   c = 24'h87CEEB;
      default: c = 24'h000000;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

### hdl/csnp_front.sv
// Character parser: takes one string byte per transfer and produces a parsed item.
// Depends on csnp_pkg.
`default_nettype none

module csnp_front (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      in_valid,
  output logic                     in_stall,
  input  wire  [7:0]               character,
  input  wire                      last,
  input  csnp_pkg::csnp_q_status_t q_stat,
  output logic                     q_push,
  output csnp_pkg::csnp_item_t     q_item
);
  import csnp_pkg::*;

  typedef enum logic [3:0] {
    PH_START, PH_HEX, PH_GOT_R, PH_GOT_G, PH_GOT_B, PH_PRE,
    PH_SIGN, PH_DIGITS, PH_SKIP, PH_DONE, PH_ENDED
  } phase_t;

  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_G      = 8'h67;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_NUL    = 8'h00;

  phase_t     phase, phase_next;
  logic [3:0] count, count_next;
  logic [8:0] accum, accum_next;
  logic       neg, neg_next;
  logic [7:0] red, red_next;
  logic [7:0] green, green_next;
  logic [7:0] blue, blue_next;
  logic       failed, failed_next;

  logic        accept;
  logic        is_dig, is_hex, is_blank;
  logic [3:0]  hex_val;
  logic [12:0] dec_sum;
  logic        close_bad;
  logic        term_comma, term_paren;
  logic        cur_ok, ok_next;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;

  // Character classes
  always_comb begin
    is_dig   = (character >= 8'h30) && (character <= 8'h39);
    is_blank = (character == CH_SPACE) || ((character >= 8'h09) && (character <= 8'h0D));
    is_hex   = is_dig
            || ((character >= 8'h41) && (character <= 8'h46))
            || ((character >= 8'h61) && (character <= 8'h66));
    hex_val  = is_dig ? character[3:0] : (character[3:0] + 4'd9);
    dec_sum  = {1'b0, accum, 3'b000} + {3'b000, accum, 1'b0} + {9'd0, character[3:0]};
    close_bad  = accum[8] || (neg && (accum != 9'd0));
    term_comma = (count < 4'd2) && (character == CH_COMMA);
    term_paren = (count == 4'd2) && (character == CH_RPAREN);
    cur_ok     = !failed && (((phase == PH_HEX) && (count == 4'd6)) || (phase == PH_DONE));
  end

  // Next-state for one byte
  always_comb begin
    phase_next  = phase;
    count_next  = count;
    accum_next  = accum;
    neg_next    = neg;
    red_next    = red;
    green_next  = green;
    blue_next   = blue;
    failed_next = failed;

    if (phase != PH_ENDED) begin
      if (character == CH_NUL) begin
        failed_next = !cur_ok;
        phase_next  = PH_ENDED;
      end else if (!failed && (phase != PH_DONE)) begin
        case (phase)
          PH_START: begin
            if (character == CH_HASH) begin
              phase_next = PH_HEX;
              count_next = 4'd0;
            end else if (character == CH_R) begin
              phase_next = PH_GOT_R;
            end else begin
              failed_next = 1'b1;
            end
          end
          PH_HEX: begin
            if (!is_hex || (count >= 4'd6)) begin
              failed_next = 1'b1;
            end else begin
              if (count < 4'd2) red_next = {red[3:0], hex_val};
              else if (count < 4'd4) green_next = {green[3:0], hex_val};
              else blue_next = {blue[3:0], hex_val};
              count_next = count + 4'd1;
            end
          end
          PH_GOT_R: begin
            if (character == CH_G) phase_next = PH_GOT_G;
            else failed_next = 1'b1;
          end
          PH_GOT_G: begin
            if (character == CH_B) phase_next = PH_GOT_B;
            else failed_next = 1'b1;
          end
          PH_GOT_B: begin
            if (character == CH_LPAREN) begin
              count_next = 4'd0;
              phase_next = PH_PRE;
              accum_next = 9'd0;
              neg_next   = 1'b0;
            end else begin
              failed_next = 1'b1;
            end
          end
          PH_PRE: begin
            if (is_blank) begin
              phase_next = PH_PRE;
            end else if (character == CH_PLUS) begin
              phase_next = PH_SIGN;
            end else if (character == CH_MINUS) begin
              phase_next = PH_SIGN;
              neg_next   = 1'b1;
            end else if (is_dig) begin
              accum_next = {5'd0, character[3:0]};
              phase_next = PH_DIGITS;
            end else begin
              failed_next = 1'b1;
            end
          end
          PH_SIGN: begin
            if (is_dig) begin
              accum_next = {5'd0, character[3:0]};
              phase_next = PH_DIGITS;
            end else begin
              failed_next = 1'b1;
            end
          end
          PH_DIGITS: begin
            if (is_dig) begin
              // saturate at 256
              accum_next = (dec_sum > 13'd256) ? 9'd256 : dec_sum[8:0];
            end else if (close_bad) begin
              failed_next = 1'b1;
            end else begin
              if (count == 4'd0) red_next = accum[7:0];
              else if (count == 4'd1) green_next = accum[7:0];
              else blue_next = accum[7:0];
              if (term_comma) begin
                count_next = count + 4'd1;
                phase_next = PH_PRE;
                accum_next = 9'd0;
                neg_next   = 1'b0;
              end else if (term_paren) begin
                phase_next = PH_DONE;
              end else begin
                phase_next = PH_SKIP;
              end
            end
          end
          PH_SKIP: begin
            if (term_comma) begin
              count_next = count + 4'd1;
              phase_next = PH_PRE;
              accum_next = 9'd0;
              neg_next   = 1'b0;
            end else if (term_paren) begin
              phase_next = PH_DONE;
            end
          end
          default: begin
            phase_next = phase;
          end
        endcase
      end
    end

    ok_next = (phase_next == PH_ENDED) ? !failed_next
            : (!failed_next && (((phase_next == PH_HEX) && (count_next == 4'd6))
                                || (phase_next == PH_DONE)));
  end

  // Item pushed on the closing transfer
  assign q_push       = accept && last;
  assign q_item.ok    = ok_next;
  assign q_item.red   = red_next;
  assign q_item.green = green_next;
  assign q_item.blue  = blue_next;

  // Parser state; returns to start after each string
  always_ff @(posedge clk) begin
    if (rst || (accept && last)) begin
      phase  <= PH_START;
      count  <= 4'd0;
      accum  <= 9'd0;
      neg    <= 1'b0;
      red    <= 8'd0;
      green  <= 8'd0;
      blue   <= 8'd0;
      failed <= 1'b0;
    end else if (accept) begin
      phase  <= phase_next;
      count  <= count_next;
      accum  <= accum_next;
      neg    <= neg_next;
      red    <= red_next;
      green  <= green_next;
      blue   <= blue_next;
      failed <= failed_next;
    end
  end

endmodule

`default_nettype wire

### hdl/csnp_fifo.sv
// Short queue of parsed items between the parser and the search unit.
// Depends on csnp_pkg.
`default_nettype none

module csnp_fifo #(
  parameter int DEPTH = 2
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      push,
  input  csnp_pkg::csnp_item_t     push_item,
  input  wire                      pop,
  output csnp_pkg::csnp_item_t     pop_item,
  output csnp_pkg::csnp_q_status_t stat
);
  import csnp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  csnp_item_t       entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign stat.full  = (count == CNT_W'(DEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_item   = entries[rd_ptr];

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_item;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

endmodule

`default_nettype wire

### hdl/csnp_back.sv
// Nearest palette search: one palette entry per cycle, then the result register.
// Depends on csnp_pkg (item type, palette table).
`default_nettype none

module csnp_back (
  input  wire                         clk,
  input  wire                         rst,
  input  csnp_pkg::csnp_q_status_t    q_stat,
  input  csnp_pkg::csnp_item_t        q_item,
  output logic                        q_pop,
  output logic                        out_valid,
  input  wire                         out_stall,
  output logic                        parsed_ok,
  output logic [csnp_pkg::CIDX_W-1:0] color_index
);
  import csnp_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINAL, S_DONE} state_t;

  state_t            state;
  csnp_item_t        item;
  logic [CIDX_W-1:0] idx;
  logic [23:0]       pal;
  logic [7:0]        ad_r, ad_g, ad_b;
  logic [15:0]       sq_r, sq_g, sq_b;
  logic              sq_valid;
  logic [CIDX_W-1:0] sq_idx;
  logic [17:0]       sum_sq;
  logic [17:0]       best_dist;
  logic [CIDX_W-1:0] best_idx;
  logic              can_emit;

  assign q_pop    = (state == S_IDLE) && !q_stat.empty;
  assign can_emit = !out_valid || !out_stall;

  // Absolute channel differences against the current entry
  always_comb begin
    pal    = palette_color(idx);
    ad_r   = (item.red   >= pal[23:16]) ? item.red   - pal[23:16] : pal[23:16] - item.red;
    ad_g   = (item.green >= pal[15:8])  ? item.green - pal[15:8]  : pal[15:8]  - item.green;
    ad_b   = (item.blue  >= pal[7:0])   ? item.blue  - pal[7:0]   : pal[7:0]   - item.blue;
    sum_sq = {2'b00, sq_r} + {2'b00, sq_g} + {2'b00, sq_b};
  end

  // Squares registered, then summed and compared in the following cycle
  always_ff @(posedge clk) begin
    sq_r   <= ad_r * ad_r;
    sq_g   <= ad_g * ad_g;
    sq_b   <= ad_b * ad_b;
    sq_idx <= idx;
    if (sq_valid && ((sq_idx == '0) || (sum_sq < best_dist))) begin
      best_idx  <= sq_idx;
      best_dist <= sum_sq;
    end
  end

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sq_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      sq_valid <= (state == S_SCAN);
      // a new result in S_DONE takes the place of the one leaving
      if (out_valid && !out_stall && (state != S_DONE)) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (!q_stat.empty) begin
            item  <= q_item;
            idx   <= '0;
            state <= q_item.ok ? S_SCAN : S_DONE;
          end
        end
        S_SCAN: begin
          if (idx == CIDX_W'(PALETTE_SIZE - 1)) state <= S_FINAL;
          else idx <= idx + 1'b1;
        end
        S_FINAL: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (can_emit) begin
            out_valid   <= 1'b1;
            parsed_ok   <= item.ok;
            color_index <= item.ok ? best_idx : '0;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### hdl/color_string_nearest_palette.sv
// Result path: a parsed string's item goes through the item queue, the queue pop, a scan
// of the 17 palette entries one per cycle, the final compare and the output register;
// a failed parse skips the scan and the final compare.
// Throughput: one character per cycle while the item queue has room; the search takes
// one string at a time and pops the next only when idle, and short strings stall the input
// once the queue is full.
// Reset: synchronous, clears parser state, queue and output valid.
`default_nettype none
`include "color_string_nearest_palette_macros.svh"

module color_string_nearest_palette #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire  [7:0] character,
  input  wire        last,
  output logic       out_valid,
  input  wire        out_stall,
  output logic       parsed_ok,
  output logic [4:0] color_index
);
  import csnp_pkg::*;

  csnp_q_status_t q_stat;
  csnp_item_t     push_item, pop_item;
  logic           q_push, q_pop;

  csnp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .character (character),
    .last      (last),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  csnp_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .stat      (q_stat)
  );

  csnp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_stat      (q_stat),
    .q_item      (pop_item),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .parsed_ok   (parsed_ok),
    .color_index (color_index)
  );

  // Checks
  `CSNP_ASSERT(a_no_overflow, q_push |-> !q_stat.full, "item pushed into a full queue")
  `CSNP_ASSERT(a_idx_range, out_valid |-> (color_index < CIDX_W'(PALETTE_SIZE)), "index range")
  `CSNP_ASSERT(a_fail_zero, (out_valid && !parsed_ok) |-> (color_index == '0), "fail index")
  `CSNP_ASSERT_ALWAYS(a_reset_clear, rst |=> (!out_valid && q_stat.empty), "reset not clear")

endmodule

`default_nettype wire

### sim/color_string_nearest_palette_chk.sv
`timescale 1ns / 100ps
// Scoreboard for color_string_nearest_palette: watches both channels, parses each
// transferred character on its own and checks every result. Depends on csnp_pkg.
module color_string_nearest_palette_chk (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        in_valid,
  input  wire                        in_stall,
  input  wire  [7:0]                 character,
  input  wire                        last,
  input  wire                        out_valid,
  input  wire                        out_stall,
  input  wire                        parsed_ok,
  input  wire  [csnp_pkg::CIDX_W-1:0] color_index,
  output int                         error_count,
  output int                         pending
);
  import csnp_pkg::*;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_SPACE   = " ";
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_HASH    = "#";
  localparam logic [7:0] CH_R       = "r";
  localparam logic [7:0] CH_G       = "g";
  localparam logic [7:0] CH_B       = "b";
  localparam logic [7:0] CH_OPEN    = "(";
  localparam logic [7:0] CH_CLOSE   = ")";
  localparam logic [7:0] CH_COMMA   = ",";
  localparam logic [7:0] CH_PLUS    = "+";
  localparam logic [7:0] CH_MINUS   = "-";
  localparam logic [7:0] CH_DIGIT_0 = "0";
  localparam logic [7:0] CH_DIGIT_9 = "9";
  localparam logic [7:0] CH_UP_A    = "A";
  localparam logic [7:0] CH_UP_F    = "F";
  localparam logic [7:0] CH_LO_A    = "a";
  localparam logic [7:0] CH_LO_F    = "f";

  localparam int HEX_DIGITS    = 6;
  localparam int LAST_COMPONENT = 2;
  localparam int COMPONENT_MAX  = 255;
  localparam int COMPONENT_SAT  = 256;

  // Palette, entry 0 in the low bits
  localparam logic [PALETTE_SIZE*24-1:0] PALETTE_RGB = {
    24'h87CEEB, 24'h000080, 24'h008080, 24'h800080, 24'h008000, 24'h808000,
    24'h800000, 24'h808080, 24'hC0C0C0, 24'hFF00FF, 24'h00FFFF, 24'hFFFF00,
    24'h0000FF, 24'h00FF00, 24'hFF0000, 24'hFFFFFF, 24'h000000
  };

  typedef enum logic [3:0] {
    SCAN_START, SCAN_HEX, SCAN_SAW_R, SCAN_SAW_G, SCAN_SAW_B, SCAN_LEAD,
    SCAN_SIGN, SCAN_DIGITS, SCAN_SKIP, SCAN_CLOSED, SCAN_ENDED
  } scan_phase_t;

  typedef struct packed {
    logic              ok;
    logic [CIDX_W-1:0] idx;
  } color_result_t;

  color_result_t expected_colors[$];

  // Parser state
  scan_phase_t phase;
  logic [3:0]  count;
  logic [8:0]  component;
  logic        minus_seen;
  logic [7:0]  red_level, green_level, blue_level;
  logic        bad;
  int          fails = 0;

  function automatic int hex_nibble(input logic [7:0] ch);
    if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) return int'(ch) - int'(CH_DIGIT_0);
    if (ch >= CH_UP_A && ch <= CH_UP_F) return 10 + int'(ch) - int'(CH_UP_A);
    if (ch >= CH_LO_A && ch <= CH_LO_F) return 10 + int'(ch) - int'(CH_LO_A);
    return -1;
  endfunction

  function automatic logic is_blank(input logic [7:0] ch);
    return ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] ch);
    return ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9;
  endfunction

  // Complete hex string or closed rgb form
  function automatic logic string_done();
    if (bad) return 1'b0;
    return (phase == SCAN_HEX && count == HEX_DIGITS) || phase == SCAN_CLOSED;
  endfunction

  // Lowest squared distance, first entry wins ties
  function automatic logic [CIDX_W-1:0] nearest_entry(input logic [7:0] r, g, b);
    logic [23:0]       rgb;
    int                dr, dg, db, d, best_d;
    logic [CIDX_W-1:0] best;
    best   = '0;
    best_d = 0;
    for (int i = 0; i < PALETTE_SIZE; i++) begin
      rgb = PALETTE_RGB[i*24 +: 24];
      dr  = int'(r) - int'(rgb[23:16]);
      dg  = int'(g) - int'(rgb[15:8]);
      db  = int'(b) - int'(rgb[7:0]);
      d   = dr * dr + dg * dg + db * db;
      if (i == 0 || d < best_d) begin
        best   = CIDX_W'(i);
        best_d = d;
      end
    end
    return best;
  endfunction

  task automatic clear_scan();
    phase       = SCAN_START;
    count       = '0;
    component   = '0;
    minus_seen  = 1'b0;
    red_level   = '0;
    green_level = '0;
    blue_level  = '0;
    bad         = 1'b0;
  endtask

  task automatic start_component();
    phase      = SCAN_LEAD;
    component  = '0;
    minus_seen = 1'b0;
  endtask

  // After a number: ',' opens the next one, ')' closes the third
  task automatic seek_terminator(input logic [7:0] ch);
    if (count < LAST_COMPONENT && ch == CH_COMMA) begin
      count = count + 1'b1;
      start_component();
    end else if (count == LAST_COMPONENT && ch == CH_CLOSE) begin
      phase = SCAN_CLOSED;
    end else begin
      phase = SCAN_SKIP;
    end
  endtask

  task automatic close_number();
    if (component > COMPONENT_MAX || (minus_seen && component != 0)) begin
      bad = 1'b1;
    end else begin
      case (count)
        4'd0:    red_level   = component[7:0];
        4'd1:    green_level = component[7:0];
        default: blue_level  = component[7:0];
      endcase
    end
  endtask

  task automatic scan_char(input logic [7:0] ch);
    int h;
    int v;
    if (!bad && phase != SCAN_CLOSED) begin
      case (phase)
        SCAN_START: begin
          if (ch == CH_HASH) begin
            phase = SCAN_HEX;
            count = '0;
          end else if (ch == CH_R) begin
            phase = SCAN_SAW_R;
          end else begin
            bad = 1'b1;
          end
        end
        SCAN_HEX: begin
          h = hex_nibble(ch);
          if (h < 0 || count >= HEX_DIGITS) begin
            bad = 1'b1;
          end else begin
            if (count < 2) red_level = {red_level[3:0], h[3:0]};
            else if (count < 4) green_level = {green_level[3:0], h[3:0]};
            else blue_level = {blue_level[3:0], h[3:0]};
            count = count + 1'b1;
          end
        end
        SCAN_SAW_R: begin
          if (ch == CH_G) phase = SCAN_SAW_G;
          else bad = 1'b1;
        end
        SCAN_SAW_G: begin
          if (ch == CH_B) phase = SCAN_SAW_B;
          else bad = 1'b1;
        end
        SCAN_SAW_B: begin
          if (ch == CH_OPEN) begin
            count = '0;
            start_component();
          end else begin
            bad = 1'b1;
          end
        end
        SCAN_LEAD: begin
          if (is_blank(ch)) begin
            // stay
          end else if (ch == CH_PLUS) begin
            phase = SCAN_SIGN;
          end else if (ch == CH_MINUS) begin
            phase      = SCAN_SIGN;
            minus_seen = 1'b1;
          end else if (is_digit(ch)) begin
            component = 9'(int'(ch) - int'(CH_DIGIT_0));
            phase     = SCAN_DIGITS;
          end else begin
            bad = 1'b1;
          end
        end
        SCAN_SIGN: begin
          if (is_digit(ch)) begin
            component = 9'(int'(ch) - int'(CH_DIGIT_0));
            phase     = SCAN_DIGITS;
          end else begin
            bad = 1'b1;
          end
        end
        SCAN_DIGITS: begin
          if (is_digit(ch)) begin
            // accumulate, saturating just past the legal range
            v = int'(component) * 10 + int'(ch) - int'(CH_DIGIT_0);
            component = (v > COMPONENT_SAT) ? 9'(COMPONENT_SAT) : 9'(v);
          end else begin
            close_number();
            if (!bad) seek_terminator(ch);
          end
        end
        SCAN_SKIP: seek_terminator(ch);
        default: ;
      endcase
    end
  endtask

  // One character transfer; the closing one queues the expected result
  task automatic take_char(input logic [7:0] ch, input logic fin);
    color_result_t res;
    if (phase != SCAN_ENDED) begin
      if (ch == CH_NUL) begin
        bad   = !string_done();
        phase = SCAN_ENDED;
      end else begin
        scan_char(ch);
      end
    end
    if (fin) begin
      res.ok  = (phase == SCAN_ENDED) ? !bad : string_done();
      res.idx = res.ok ? nearest_entry(red_level, green_level, blue_level) : '0;
      expected_colors.push_back(res);
      clear_scan();
    end
  endtask

  // Result check first, then the character transfer of the same edge
  always @(posedge clk) begin : watch
    color_result_t want;
    if (rst) begin
      clear_scan();
      expected_colors.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_colors.size() == 0) begin
          $error("result transfer with nothing expected: parsed_ok=%0d color_index=%0d",
                 parsed_ok, color_index);
          fails++;
        end else begin
          want = expected_colors.pop_front();
          if (parsed_ok !== want.ok) begin
            $error("parsed_ok: expected %0d, got %0d", want.ok, parsed_ok);
            fails++;
          end
          if (color_index !== want.idx) begin
            $error("color_index: expected %0d, got %0d", want.idx, color_index);
            fails++;
          end
        end
      end
      if (in_valid && !in_stall) take_char(character, last);
    end
    error_count <= fails;
    pending     <= expected_colors.size();
  end

endmodule

### sim/color_string_nearest_palette_tb.sv
`timescale 1ns / 100ps
// Top of the color_string_nearest_palette bench: clock, reset, character stimulus,
// result stall pattern and verdict. Needs the block and color_string_nearest_palette_chk.
module color_string_nearest_palette_tb;

  localparam int TOTAL_CHARS  = 1600;
  localparam int CALM_CHARS   = 200;   // final stretch without idling
  localparam int QUIET_LIMIT  = 2000;  // far above one search behind stalls
  localparam int TAIL_CYCLES  = 60;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_SPACE   = " ";
  localparam logic [7:0] BLANK_LO   = 8'h09;
  localparam logic [7:0] BLANK_HI   = 8'h0D;
  localparam logic [7:0] CH_HASH    = "#";
  localparam logic [7:0] CH_CLOSE   = ")";
  localparam logic [7:0] CH_COMMA   = ",";
  localparam logic [7:0] CH_PLUS    = "+";
  localparam logic [7:0] CH_MINUS   = "-";
  localparam logic [7:0] CH_DIGIT_0 = "0";
  localparam logic [7:0] CH_DIGIT_9 = "9";
  localparam logic [7:0] CH_LO_A    = "a";
  localparam logic [7:0] CASE_SHIFT = 8'h20;
  localparam logic [7:0] CH_BYTE_MAX = 8'hFF;

  // Component values near palette levels and tie points
  localparam logic [79:0] LEVELS = {
    8'd0, 8'd64, 8'd96, 8'd128, 8'd135, 8'd160, 8'd192, 8'd206, 8'd235, 8'd255
  };

  logic       clk;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic [7:0] character = 8'h00;
  logic       last      = 1'b0;
  logic       out_stall = 1'b0;
  wire        in_stall;
  wire        out_valid;
  wire        parsed_ok;
  wire  [4:0] color_index;
  int         error_count;
  int         pending;

  logic [7:0] string_bytes[$];
  string      hex_text     = "0123456789abcdef";
  int         chars_sent   = 0;
  int         gap_pct      = 0;
  logic       idle_enabled = 1'b1;
  int         stall_pct    = 0;
  int         stall_left   = 0;
  int         stall_epoch  = 0;
  int         quiet_cycles = 0;
  int         kind;
  int         keep;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  color_string_nearest_palette u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .character   (character),
    .last        (last),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .parsed_ok   (parsed_ok),
    .color_index (color_index)
  );

  color_string_nearest_palette_chk u_chk (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .character   (character),
    .last        (last),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .parsed_ok   (parsed_ok),
    .color_index (color_index),
    .error_count (error_count),
    .pending     (pending)
  );

  // Result side stall bursts, pressure level redrawn at the start of each stall epoch
  always @(posedge clk) begin
    stall_epoch <= stall_epoch + 1;
    if (stall_epoch % 128 == 0) begin
      case ($urandom_range(0, 2))
        0:       stall_pct <= 0;
        1:       stall_pct <= 10;
        default: stall_pct <= 40;
      endcase
    end
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (idle_enabled && !rst && $urandom_range(0, 99) < stall_pct) begin
      stall_left <= $urandom_range(0, 6);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("color_string_nearest_palette_tb: done, errors");
      $finish;
    end
  end

  // One character transfer, with an optional idle burst ahead of it
  task automatic send_char(input logic [7:0] ch, input logic fin);
    if (idle_enabled && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    character <= ch;
    last      <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_string();
    int n;
    n = string_bytes.size();
    for (int i = 0; i < n; i++) send_char(string_bytes[i], i == n - 1);
    string_bytes.delete();
  endtask

  task automatic push_byte(input logic [7:0] ch);
    string_bytes.push_back(ch);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) string_bytes.push_back(s[i]);
  endtask

  task automatic send_text(input string s);
    push_text(s);
    send_string();
  endtask

  // Filler that ends a number but is neither a digit nor a separator
  task automatic add_junk();
    logic [7:0] ch;
    repeat ($urandom_range(1, 3)) begin
      ch = 8'($urandom_range(1, 255));
      while ((ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) || ch == CH_COMMA || ch == CH_CLOSE)
        ch = 8'($urandom_range(1, 255));
      push_byte(ch);
    end
  endtask

  // '#' and hex digits of mixed case, mostly exactly six
  task automatic build_hex();
    int         n;
    logic [7:0] ch;
    n = ($urandom_range(0, 9) < 8) ? 6 : $urandom_range(4, 8);
    push_byte(CH_HASH);
    repeat (n) begin
      ch = hex_text[$urandom_range(0, 15)];
      if (ch >= CH_LO_A && $urandom_range(0, 1) == 1) ch = ch - CASE_SHIFT;
      push_byte(ch);
    end
  endtask

  // rgb() form with random blanks, signs, leading zeros, filler and tail
  task automatic build_rgb();
    int v;
    int sel;
    push_text("rgb(");
    for (int k = 0; k < 3; k++) begin
      repeat ($urandom_range(0, 2)) begin
        if ($urandom_range(0, 5) == 0) push_byte(CH_SPACE);
        else push_byte(8'($urandom_range(BLANK_LO, BLANK_HI)));
      end
      sel = $urandom_range(0, 19);
      if (sel == 0) begin
        push_byte(CH_MINUS);
        v = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 300) : 0;
      end else begin
        if (sel < 3) push_byte(CH_PLUS);
        sel = $urandom_range(0, 19);
        if (sel < 2) v = $urandom_range(256, 99999);
        else if (sel < 7) v = int'(LEVELS[$urandom_range(0, 9)*8 +: 8]);
        else v = $urandom_range(0, 255);
      end
      if ($urandom_range(0, 9) == 0) push_byte(CH_DIGIT_0);
      push_text($sformatf("%0d", v));
      if ($urandom_range(0, 3) == 0) add_junk();
      push_byte((k < 2) ? CH_COMMA : CH_CLOSE);
    end
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(1, 255)));
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: palette hits, hex length and digit errors, rgb edge cases
    gap_pct = 20;
    send_text("#000000");
    send_text("#FFffFF");
    send_text("#87CEeb");
    send_text("#C0C0C1");
    send_text("#12345");
    send_text("#1234567");
    send_text("#12G456");
    send_text("rgb(255,0,0)");
    push_text("rgb( +0,");
    for (int b = BLANK_LO; b <= BLANK_HI; b++) push_byte(8'(b));
    send_text("-0 ,255)tail");
    send_text("rgb(-1,0,0)");
    send_text("rgb(256,0,0)");
    send_text("rgb(0099999,1,1)");
    send_text("rgb(64 px,0 ;x,0)x");
    send_text("rgb(1,2,3");
    send_text("rgb(1,2");
    send_text("rgb(+,1,2)");
    send_text("rgb(,1,2)");
    send_text("rgb(1,2,3,4)");
    send_text("red");
    push_byte(CH_NUL);
    send_string();
    push_text("#123456");
    push_byte(CH_NUL);
    send_text("zz");
    push_text("#123456");
    push_byte(CH_NUL);
    send_string();
    push_text("rgb(1,2,3)),");
    push_byte(CH_BYTE_MAX);
    send_string();
    push_byte(CH_BYTE_MAX);
    send_text("#");

    // Random strings: mostly well formed, some broken, some noise
    while (chars_sent < TOTAL_CHARS) begin
      if (chars_sent > TOTAL_CHARS - CALM_CHARS) idle_enabled = 1'b0;
      case ($urandom_range(0, 2))
        0:       gap_pct = 0;
        1:       gap_pct = 10;
        default: gap_pct = 50;
      endcase
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        build_hex();
      end else if (kind < 75) begin
        build_rgb();
      end else if (kind < 85) begin
        if ($urandom_range(0, 1) == 1) push_byte(($urandom_range(0, 1) == 1) ? CH_HASH : "r");
        repeat ($urandom_range(1, 8)) push_byte(8'($urandom_range(0, 255)));
      end else begin
        // well-formed start, then cut short or one byte overwritten
        if ($urandom_range(0, 1) == 1) build_hex();
        else build_rgb();
        if ($urandom_range(0, 1) == 1) begin
          keep = $urandom_range(1, string_bytes.size() - 1);
          while (string_bytes.size() > keep) void'(string_bytes.pop_back());
        end else begin
          string_bytes[$urandom_range(0, string_bytes.size() - 1)] = 8'($urandom_range(0, 255));
        end
      end
      if ($urandom_range(0, 19) == 0) begin
        push_byte(CH_NUL);
        repeat ($urandom_range(0, 3)) push_byte(8'($urandom_range(0, 255)));
      end
      send_string();
    end
    in_valid <= 1'b0;

    // Drain outstanding results, then allow for one more search
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && pending == 0) begin
      $display("color_string_nearest_palette_tb: done, clean");
    end else begin
      $display("color_string_nearest_palette_tb: done, errors");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hdl
hdl/csnp_pkg.sv
hdl/csnp_front.sv
hdl/csnp_fifo.sv
hdl/csnp_back.sv
hdl/color_string_nearest_palette.sv
sim/color_string_nearest_palette_chk.sv
sim/color_string_nearest_palette_tb.sv
